// ----- rtl/gcc_pkg.sv -----
`default_nettype none
package gcc_pkg;

	localparam int MAP_W_DEF = 64;
	localparam int MAP_H_DEF = 64;
	localparam int FRAC_DEF  = 10;

	// divisor width of the shared serial divider (ray magnitudes are held in 17 bits)
	localparam int DSW = 17;

	localparam logic [15:0] RST_PLAYER_X = 16'd0;
	localparam logic [15:0] RST_PLAYER_Y = 16'd0;
	localparam logic [15:0] RST_DIR_X    = 16'd16384;
	localparam logic [15:0] RST_DIR_Y    = 16'd0;
	localparam logic [15:0] RST_PLANE_X  = 16'd0;
	localparam logic [15:0] RST_PLANE_Y  = 16'd10813;
	localparam logic [11:0] RST_SCR_W    = 12'd640;
	localparam logic [11:0] RST_SCR_H    = 12'd480;

	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_WALL  = 2'd1;
	localparam logic [1:0] KIND_DOOR  = 2'd2;
	localparam logic [1:0] KIND_RSVD  = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	typedef enum logic [2:0] {
		REG_PLAYER_X,
		REG_PLAYER_Y,
		REG_DIR_X,
		REG_DIR_Y,
		REG_PLANE_X,
		REG_PLANE_Y,
		REG_SCR_W,
		REG_SCR_H
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_DX,
		S_DXW,
		S_DY,
		S_DYW,
		S_SET1,
		S_SET2,
		S_STEP,
		S_CHECK,
		S_NUM,
		S_DD,
		S_DDW,
		S_DL,
		S_DLW,
		S_OUT
	} gcc_state_t;

endpackage
`default_nettype wire

// ----- rtl/gcc_div.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle; done pulses when quotient is ready
module gcc_div #(
	parameter int DVW = gcc_pkg::FRAC_DEF + 22
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [DVW-1:0]           dividend,
	input  wire logic [gcc_pkg::DSW-1:0]  divisor,
	output logic                          done,
	output logic [DVW-1:0]                quotient
);
	import gcc_pkg::*;

	localparam int CNTW = $clog2(DVW);

	logic [DVW-1:0]  num_q;
	logic [DSW-1:0]  rem_q;
	logic [DSW-1:0]  den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DSW:0]    rem_sh;
	logic            ge;
	logic [DSW:0]    rem_sub;

	always_comb begin
		rem_sh  = {rem_q, num_q[DVW-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DVW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DVW-2:0], ge};
			rem_q <= ge ? rem_sub[DSW-1:0] : rem_sh[DSW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule
`default_nettype wire

// ----- rtl/grid_ray_caster_column_unit.sv -----
`default_nettype none
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-----------------------------------------
// input   | in        | in_valid/in_stall  | cmd cell_x cell_y cell_kind column
// output  | out       | out_valid/out_stall| out_column found_wall wall_side is_door
//         |           |                    | hit_cell_x hit_cell_y wall_distance
//         |           |                    | draw_top draw_bottom
// config  | in        | cfg_we             | cfg_index cfg_data
//
// Sequence: a cell write is done in the idle state. A cast runs up to four passes of the
//   shared serial divider (ray x, ray y, distance, line height) plus a step/read state and
//   a map check state per DDA step.
// Reset: map RAM is swept to empty, one cell per cycle, over all MAP_WIDTH*MAP_HEIGHT
//   cells (4096 by default); input is stalled meanwhile, config writes still land.
// Stalls: one item in flight; a finished result sits in the output register, so the
//   next item is taken while it waits. The sequencer holds only when a second result
//   is ready and the output register is still full.
module grid_ray_caster_column_unit #(
	parameter int MAP_WIDTH  = gcc_pkg::MAP_W_DEF,
	parameter int MAP_HEIGHT = gcc_pkg::MAP_H_DEF,
	parameter int FRAC_BITS  = gcc_pkg::FRAC_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        cmd,
	input  wire logic [5:0]  cell_x,
	input  wire logic [5:0]  cell_y,
	input  wire logic [1:0]  cell_kind,
	input  wire logic [10:0] column,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [10:0]      out_column,
	output logic             found_wall,
	output logic             wall_side,
	output logic             is_door,
	output logic [5:0]       hit_cell_x,
	output logic [5:0]       hit_cell_y,
	output logic [15:0]      wall_distance,
	output logic [10:0]      draw_top,
	output logic [10:0]      draw_bottom,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import gcc_pkg::*;

	localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = 8;                // cell coord, signed, -1..64
	localparam int PW    = FRAC_BITS + 26;   // cross products dist*ray
	localparam int DVW   = FRAC_BITS + 22;   // divider dividend / quotient
	localparam int ANW   = FRAC_BITS + 8;    // |boundary - position|
	localparam int STEPS = MAP_WIDTH + MAP_HEIGHT + 2;
	localparam int SCW   = $clog2(STEPS);
	localparam int FW    = FRAC_BITS + 1;

	// config registers
	logic [15:0]        player_x_q, player_y_q;
	logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [11:0]        scr_w_q, scr_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q <= RST_PLAYER_X;
			player_y_q <= RST_PLAYER_Y;
			dir_x_q    <= RST_DIR_X;
			dir_y_q    <= RST_DIR_Y;
			plane_x_q  <= RST_PLANE_X;
			plane_y_q  <= RST_PLANE_Y;
			scr_w_q    <= RST_SCR_W;
			scr_h_q    <= RST_SCR_H;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PLAYER_X: player_x_q <= cfg_data;
				REG_PLAYER_Y: player_y_q <= cfg_data;
				REG_DIR_X:    dir_x_q    <= cfg_data;
				REG_DIR_Y:    dir_y_q    <= cfg_data;
				REG_PLANE_X:  plane_x_q  <= cfg_data;
				REG_PLANE_Y:  plane_y_q  <= cfg_data;
				REG_SCR_W:    scr_w_q    <= cfg_data[11:0];
				REG_SCR_H:    scr_h_q    <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	gcc_state_t state_q, state_d;

	// item registers
	logic [10:0]          col_q;
	logic signed [12:0]   num_q;
	logic signed [28:0]   prodx_q, prody_q;
	logic signed [17:0]   rx_q, ry_q;
	logic [16:0]          ax_q, ay_q;
	logic                 negx_q, negy_q, start_ok_q;
	logic [FW-1:0]        dx0_q, dy0_q;
	logic [CW-1:0]        cx_q, cy_q;
	logic [PW-1:0]        px_q, py_q;
	logic                 face_q, hit_q, door_q;
	logic [SCW-1:0]       stepc_q;
	logic [ANW-1:0]       an_q;
	logic [DSW-1:0]       den_q;
	logic [15:0]          dist_q;
	logic [10:0]          top_q, bot_q;
	logic [AW-1:0]        clr_q;
	logic                 out_valid_q;

	// map RAM
	logic [1:0]    mem [DEPTH];
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [1:0]    mem_wd, mem_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (mem_re)
			mem_rd_q <= mem[mem_ra];
	end

	// shared divider
	logic            div_start, div_done;
	logic [DVW-1:0]  div_dvd, div_quo;
	logic [DSW-1:0]  div_dsr;

	gcc_div #(.DVW(DVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	logic acc, ld_out;
	assign in_stall = (state_q != S_IDLE);
	assign acc      = in_valid && !in_stall;
	assign ld_out   = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// combinational datapath pieces
	logic [28:0]        absx, absy;
	logic signed [17:0] qsx, rx_n;
	logic [16:0]        ax_c, ay_c;
	logic               start_ok_c;
	logic               x_first;
	logic [CW-1:0]      cx_n, cy_n;
	logic               leave;
	logic [1:0]         kind;
	logic [6:0]         bnd;
	logic signed [ANW-1:0] nv;
	logic [DVW-1:0]     dq;
	logic [15:0]        dist_c;
	logic [DVW-1:0]     lh2;
	logic [10:0]        half;
	logic [DVW:0]       bsum;
	logic [DVW:0]       bclip;
	logic [10:0]        top_c, bot_c;
	logic               wr_ok;

	always_comb begin
		absx = prodx_q[28] ? 29'(-prodx_q) : 29'(prodx_q);
		absy = prody_q[28] ? 29'(-prody_q) : 29'(prody_q);
		// signed quotient added to direction; sign follows the product
		if ((state_q == S_DXW) ? prodx_q[28] : prody_q[28])
			qsx = -$signed({1'b0, div_quo[16:0]});
		else
			qsx = $signed({1'b0, div_quo[16:0]});
		rx_n = ((state_q == S_DXW) ? 18'(dir_x_q) : 18'(dir_y_q)) + qsx;

		ax_c = rx_q[17] ? 17'(-rx_q) : 17'(rx_q);
		ay_c = ry_q[17] ? 17'(-ry_q) : 17'(ry_q);
		start_ok_c = ((ax_c != '0) || (ay_c != '0))
			&& (17'(player_x_q >> FRAC_BITS) < 17'(MAP_WIDTH))
			&& (17'(player_y_q >> FRAC_BITS) < 17'(MAP_HEIGHT));

		// DDA step; ties go to y
		x_first = px_q < py_q;
		cx_n = cx_q;
		cy_n = cy_q;
		if (x_first)
			cx_n = cx_q + (negx_q ? {CW{1'b1}} : CW'(1));
		else
			cy_n = cy_q + (negy_q ? {CW{1'b1}} : CW'(1));
		leave = cx_n[CW-1] || cy_n[CW-1]
			|| ($signed(cx_n) >= $signed(CW'(MAP_WIDTH)))
			|| ($signed(cy_n) >= $signed(CW'(MAP_HEIGHT)));
		kind = mem_rd_q;

		// crossed boundary minus position
		if (!face_q) begin
			bnd = cx_q[6:0] + 7'(negx_q);
			nv  = $signed((ANW'(bnd) << FRAC_BITS) - ANW'(player_x_q));
		end else begin
			bnd = cy_q[6:0] + 7'(negy_q);
			nv  = $signed((ANW'(bnd) << FRAC_BITS) - ANW'(player_y_q));
		end

		// zero distance reads as 1.0, then saturate
		dq = ((den_q == '0) || (div_quo == '0)) ? (DVW'(1) << FRAC_BITS) : div_quo;
		dist_c = (dq > DVW'(16'hFFFF)) ? 16'hFFFF : dq[15:0];

		lh2   = div_quo >> 1;
		half  = scr_h_q[11:1];
		top_c = (lh2 > DVW'(half)) ? 11'd0 : half - lh2[10:0];
		bsum  = (DVW + 1)'(half) + (DVW + 1)'(lh2);
		bclip = (bsum >= (DVW + 1)'(scr_h_q)) ? (DVW + 1)'(scr_h_q - 12'd1) : bsum;
		bot_c = (bclip > (DVW + 1)'(2047)) ? 11'd2047 : bclip[10:0];

		wr_ok = ({1'b0, cell_x} < 7'(MAP_WIDTH)) && ({1'b0, cell_y} < 7'(MAP_HEIGHT));
	end

	// sequencer: next state, RAM and divider controls
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_wa    = clr_q;
		mem_wd    = KIND_EMPTY;
		mem_re    = 1'b0;
		mem_ra    = AW'(cx_n[CW-2:0]) * AW'(MAP_HEIGHT) + AW'(cy_n[CW-2:0]);
		div_start = 1'b0;
		div_dvd   = DVW'(absx);
		div_dsr   = DSW'(scr_w_q);
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == AW'(DEPTH - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (acc && cmd == CMD_WRITE) begin
					mem_we = wr_ok;
					mem_wa = AW'(cell_x) * AW'(MAP_HEIGHT) + AW'(cell_y);
					mem_wd = (cell_kind == KIND_RSVD) ? KIND_EMPTY : cell_kind;
				end else if (acc && ({1'b0, column} < scr_w_q)) begin
					state_d = S_MUL;
				end
			end
			S_MUL: state_d = S_DX;
			S_DX: begin
				div_start = 1'b1;
				state_d   = S_DXW;
			end
			S_DXW: if (div_done) state_d = S_DY;
			S_DY: begin
				div_start = 1'b1;
				div_dvd   = DVW'(absy);
				state_d   = S_DYW;
			end
			S_DYW: if (div_done) state_d = S_SET1;
			S_SET1: state_d = S_SET2;
			S_SET2: state_d = start_ok_q ? S_STEP : S_OUT;
			S_STEP: begin
				if (leave) begin
					state_d = S_OUT;
				end else begin
					mem_re  = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (kind == KIND_WALL || kind == KIND_DOOR)
					state_d = S_NUM;
				else if (stepc_q == SCW'(STEPS - 1))
					state_d = S_OUT;
				else
					state_d = S_STEP;
			end
			S_NUM: state_d = S_DD;
			S_DD: begin
				div_start = 1'b1;
				div_dvd   = {an_q, 14'd0};
				div_dsr   = den_q;
				state_d   = S_DDW;
			end
			S_DDW: if (div_done) state_d = (scr_h_q == '0) ? S_OUT : S_DL;
			S_DL: begin
				div_start = 1'b1;
				div_dvd   = DVW'(scr_h_q) << FRAC_BITS;
				div_dsr   = DSW'(dist_q);
				state_d   = S_DLW;
			end
			S_DLW: if (div_done) state_d = S_OUT;
			S_OUT: if (ld_out) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + 1'b1;
		end
	end

	// per-item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				col_q <= column;
				num_q <= $signed({1'b0, column, 1'b0}) - $signed({1'b0, scr_w_q});
			end
			S_MUL: begin
				prodx_q <= plane_x_q * num_q;
				prody_q <= plane_y_q * num_q;
			end
			S_DXW: if (div_done) rx_q <= rx_n;
			S_DYW: if (div_done) ry_q <= rx_n;
			S_SET1: begin
				ax_q       <= ax_c;
				ay_q       <= ay_c;
				negx_q     <= rx_q[17];
				negy_q     <= ry_q[17];
				start_ok_q <= start_ok_c;
				dx0_q <= rx_q[17] ? FW'(player_x_q[FRAC_BITS-1:0])
					: (FW'(1) << FRAC_BITS) - FW'(player_x_q[FRAC_BITS-1:0]);
				dy0_q <= ry_q[17] ? FW'(player_y_q[FRAC_BITS-1:0])
					: (FW'(1) << FRAC_BITS) - FW'(player_y_q[FRAC_BITS-1:0]);
				cx_q  <= CW'(player_x_q >> FRAC_BITS);
				cy_q  <= CW'(player_y_q >> FRAC_BITS);
				hit_q <= 1'b0;
			end
			S_SET2: begin
				px_q    <= PW'(dx0_q * ay_q);
				py_q    <= PW'(dy0_q * ax_q);
				stepc_q <= '0;
			end
			S_STEP: begin
				cx_q   <= cx_n;
				cy_q   <= cy_n;
				face_q <= !x_first;
				if (x_first)
					px_q <= px_q + (PW'(ay_q) << FRAC_BITS);
				else
					py_q <= py_q + (PW'(ax_q) << FRAC_BITS);
			end
			S_CHECK: begin
				stepc_q <= stepc_q + 1'b1;
				if (kind == KIND_WALL || kind == KIND_DOOR) begin
					hit_q  <= 1'b1;
					door_q <= (kind == KIND_DOOR);
				end
			end
			S_NUM: begin
				an_q  <= nv[ANW-1] ? ANW'(-nv) : ANW'(nv);
				den_q <= face_q ? ay_q : ax_q;
			end
			S_DDW: begin
				if (div_done) begin
					dist_q <= dist_c;
					top_q  <= 11'd0;
					bot_q  <= 11'd0;
				end
			end
			S_DLW: begin
				if (div_done) begin
					top_q <= top_c;
					bot_q <= bot_c;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ld_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_column    <= col_q;
			found_wall    <= hit_q;
			wall_side     <= hit_q & face_q;
			is_door       <= hit_q & door_q;
			hit_cell_x    <= hit_q ? cx_q[5:0] : 6'd0;
			hit_cell_y    <= hit_q ? cy_q[5:0] : 6'd0;
			wall_distance <= hit_q ? dist_q : 16'd0;
			draw_top      <= hit_q ? top_q : 11'd0;
			draw_bottom   <= hit_q ? bot_q : 11'd0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall)
		else $error("input taken during map clear");

	a_check_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> $past(state_q) == S_STEP)
		else $error("map check without a read");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DXW || state_q == S_DYW
			|| state_q == S_DDW || state_q == S_DLW))
		else $error("divider result not awaited");

	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found_wall |-> wall_distance != 16'd0)
		else $error("hit with zero distance");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found_wall |-> wall_distance == 16'd0 && draw_top == 11'd0
			&& draw_bottom == 11'd0 && !is_door && !wall_side)
		else $error("miss with nonzero fields");
`endif

endmodule
`default_nettype wire

// ----- tb/grid_ray_caster_column_checker.sv -----
module grid_ray_caster_column_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        cmd,
	input  wire logic [5:0]  cell_x,
	input  wire logic [5:0]  cell_y,
	input  wire logic [1:0]  cell_kind,
	input  wire logic [10:0] column,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [10:0] out_column,
	input  wire logic        found_wall,
	input  wire logic        wall_side,
	input  wire logic        is_door,
	input  wire logic [5:0]  hit_cell_x,
	input  wire logic [5:0]  hit_cell_y,
	input  wire logic [15:0] wall_distance,
	input  wire logic [10:0] draw_top,
	input  wire logic [10:0] draw_bottom,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               fail_count,
	output int               pending
);
	import gcc_pkg::*;

	localparam int MW = 64;
	localparam int MH = 64;
	localparam int FB = 10;

	typedef struct packed {
		logic [10:0] col;
		logic        found;
		logic        side;
		logic        door;
		logic [5:0]  hx;
		logic [5:0]  hy;
		logic [15:0] wdist;
		logic [10:0] top;
		logic [10:0] bot;
	} column_hit_t;

	logic [1:0] grid [MW*MH];
	logic [15:0] pos_x, pos_y;
	logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
	logic [11:0] scr_w, scr_h;
	column_hit_t hit_queue [$];

	assign pending = hit_queue.size();

	function automatic column_hit_t cast_column(input logic [10:0] col);
		column_hit_t r;
		longint num, rx, ry, ax, ay, dxs, dys, n, d, lh, half, t, b, one;
		int sgx, sgy, cx, cy, i;
		logic hit, face;
		logic [1:0] k;
		one = 1 << FB;
		r = '0;
		hit = 0;
		face = 0;
		num = 2 * longint'(col) - longint'(scr_w);
		rx = longint'(dir_x) + (longint'(plane_x) * num) / longint'(scr_w);
		ry = longint'(dir_y) + (longint'(plane_y) * num) / longint'(scr_w);
		ax = rx < 0 ? -rx : rx;
		ay = ry < 0 ? -ry : ry;
		sgx = rx < 0 ? -1 : 1;
		sgy = ry < 0 ? -1 : 1;
		cx = pos_x >> FB;
		cy = pos_y >> FB;
		dxs = rx < 0 ? longint'(pos_x % one) : one - longint'(pos_x % one);
		dys = ry < 0 ? longint'(pos_y % one) : one - longint'(pos_y % one);
		if ((ax != 0 || ay != 0) && cx < MW && cy < MH) begin
			for (i = 0; i < MW + MH + 2; i++) begin
				if (dxs * ay < dys * ax) begin
					dxs += one; cx += sgx; face = 0;
				end else begin
					dys += one; cy += sgy; face = 1;
				end
				if (cx < 0 || cx >= MW || cy < 0 || cy >= MH) break;
				k = grid[cx*MH + cy];
				if (k == KIND_WALL || k == KIND_DOOR) begin
					hit = 1;
					r.door = (k == KIND_DOOR);
					break;
				end
			end
		end
		r.col = col;
		if (hit) begin
			if (!face)
				n = (longint'(cx + (sgx < 0)) << FB) - longint'(pos_x);
			else
				n = (longint'(cy + (sgy < 0)) << FB) - longint'(pos_y);
			if (n < 0) n = -n;
			d = face ? ((n << 14) / ay) : ((n << 14) / ax);
			if (d == 0) d = one;
			if (d > 65535) d = 65535;
			r.found = 1;
			r.side = face;
			r.hx = cx[5:0];
			r.hy = cy[5:0];
			r.wdist = d[15:0];
			if (scr_h != 0) begin
				lh = (longint'(scr_h) << FB) / d;
				half = scr_h / 2;
				t = half - lh / 2;
				b = half + lh / 2;
				if (b >= scr_h) b = longint'(scr_h) - 1;
				r.top = t < 0 ? 11'd0 : (t > 2047 ? 11'd2047 : t[10:0]);
				r.bot = b < 0 ? 11'd0 : (b > 2047 ? 11'd2047 : b[10:0]);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		column_hit_t exp_r, got_r;
		if (!arst_n) begin
			foreach (grid[i]) grid[i] = KIND_EMPTY;
			pos_x = RST_PLAYER_X;
			pos_y = RST_PLAYER_Y;
			dir_x = RST_DIR_X;
			dir_y = RST_DIR_Y;
			plane_x = RST_PLANE_X;
			plane_y = RST_PLANE_Y;
			scr_w = RST_SCR_W;
			scr_h = RST_SCR_H;
			hit_queue.delete();
			fail_count = 0;
		end else begin
			// outputs first: a result never comes out in the cycle of its own item
			if (out_valid && !out_stall) begin
				got_r = {out_column, found_wall, wall_side, is_door, hit_cell_x,
					hit_cell_y, wall_distance, draw_top, draw_bottom};
				if (hit_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result col %0d", out_column);
				end else begin
					exp_r = hit_queue.pop_front();
					if (got_r !== exp_r) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch col %0d: exp %p got %p", exp_r.col, exp_r, got_r);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_PLAYER_X: pos_x = cfg_data;
					REG_PLAYER_Y: pos_y = cfg_data;
					REG_DIR_X:    dir_x = cfg_data;
					REG_DIR_Y:    dir_y = cfg_data;
					REG_PLANE_X:  plane_x = cfg_data;
					REG_PLANE_Y:  plane_y = cfg_data;
					REG_SCR_W:    scr_w = cfg_data[11:0];
					REG_SCR_H:    scr_h = cfg_data[11:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_WRITE) begin
					grid[cell_x*MH + cell_y] = (cell_kind == KIND_RSVD) ? KIND_EMPTY : cell_kind;
				end else if (column < scr_w) begin
					hit_queue.push_back(cast_column(column));
				end
			end
		end
	end
endmodule

// ----- tb/tb_grid_ray_caster_column_unit.sv -----
module tb_grid_ray_caster_column_unit;
	import gcc_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        cmd = CMD_WRITE;
	logic [5:0]  cell_x = 0;
	logic [5:0]  cell_y = 0;
	logic [1:0]  cell_kind = KIND_EMPTY;
	logic [10:0] column = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [10:0] out_column;
	logic        found_wall, wall_side, is_door;
	logic [5:0]  hit_cell_x, hit_cell_y;
	logic [15:0] wall_distance;
	logic [10:0] draw_top, draw_bottom;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = 0;
	logic [15:0] cfg_data = 0;
	int          fail_count, pending;
	int          cur_w = 640;

	always #5 clk = ~clk;

	grid_ray_caster_column_unit u_top (.*);

	grid_ray_caster_column_checker u_chk (.*);

	// receiver: stall pattern switches between four modes, each held for a random stretch
	int stall_mode = 0;
	int stall_cnt = 0;
	always @(posedge clk) begin
		if (stall_cnt == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_cnt <= $urandom_range(50, 400);
		end else
			stall_cnt <= stall_cnt - 1;
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// one item; holds valid until accepted, leaves it up for back-to-back items
	task automatic send_item(input logic c, input logic [5:0] x, input logic [5:0] y,
		input logic [1:0] k, input logic [10:0] col);
		cmd <= c;
		cell_x <= x;
		cell_y <= y;
		cell_kind <= k;
		column <= col;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic write_cell(input int x, input int y, input logic [1:0] k);
		send_item(CMD_WRITE, x, y, k, $urandom);
	endtask

	task automatic cast_col(input int col);
		send_item(CMD_CAST, $urandom, $urandom, $urandom, col);
	endtask

	// wait for all results, then a further margin
	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// write enable stays up across a run of writes; set_view drops it at the end
	task automatic set_reg(input cfg_reg_t idx, input logic [15:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		if (idx == REG_SCR_W) cur_w = v[11:0];
	endtask

	task automatic set_view(input logic [15:0] px, input logic [15:0] py,
		input logic [15:0] dx, input logic [15:0] dy,
		input logic [15:0] plx, input logic [15:0] ply,
		input logic [11:0] w, input logic [11:0] h);
		set_reg(REG_PLAYER_X, px);
		set_reg(REG_PLAYER_Y, py);
		set_reg(REG_DIR_X, dx);
		set_reg(REG_DIR_Y, dy);
		set_reg(REG_PLANE_X, plx);
		set_reg(REG_PLANE_Y, ply);
		set_reg(REG_SCR_W, w);
		set_reg(REG_SCR_H, h);
		cfg_we <= 0;
	endtask

	// walls and doors around the edge, with 40 random interior writes of any kind
	task automatic random_room;
		int i;
		for (i = 0; i < 64; i++) begin
			write_cell(i, 0, KIND_WALL);
			write_cell(i, 63, KIND_DOOR);
			write_cell(0, i, KIND_DOOR);
			write_cell(63, i, KIND_WALL);
		end
		for (i = 0; i < 40; i++)
			write_cell($urandom_range(1, 62), $urandom_range(1, 62), $urandom);
	endtask

	task automatic random_casts(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				write_cell($urandom, $urandom, $urandom);
			else if ($urandom_range(0, 19) == 0)
				cast_col($urandom_range(cur_w, 2047));
			else
				cast_col($urandom_range(0, cur_w - 1));
			if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 200));
		end
	endtask

	initial begin
		int i;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// directed: empty map casts leave the grid, reserved kind, corners
		cast_col(0);
		cast_col(639);
		cast_col(640);
		cast_col(2047);
		write_cell(5, 0, KIND_WALL);
		write_cell(63, 63, KIND_DOOR);
		write_cell(10, 10, KIND_RSVD);
		write_cell(2, 2, KIND_WALL);
		cast_col(320);
		drain();
		// player at cell (1,1) facing +x, tiny screen, zero-height screen
		set_view(16'h0600, 16'h0600, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 12'd1, 12'd0);
		cast_col(0);
		write_cell(4, 1, KIND_DOOR);
		cast_col(0);
		drain();
		// null ray, extreme positions
		set_view(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd2048, 12'd2048);
		cast_col(1024);
		cast_col(2047);
		drain();
		set_view(16'h0400, 16'h0400, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 12'd4, 12'd2048);
		cast_col(0);
		cast_col(3);
		drain();
		set_view(16'h0401, 16'h7C00, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 12'd0, 12'd1);
		cast_col(0);
		drain();

		random_room();
		for (i = 0; i < 12; i++) begin
			drain();
			set_view($urandom_range(1024, 63 * 1024 - 1), $urandom_range(1024, 63 * 1024 - 1),
				$urandom, $urandom, $urandom, $urandom,
				(i % 4 == 0) ? 12'd2048 : $urandom_range(1, 800),
				(i % 3 == 0) ? $urandom : $urandom_range(1, 2048));
			random_casts(80);
			if (i == 6) random_room();
		end
		drain();
		if (fail_count == 0)
			$display("[grid_ray_caster_column_unit] OK");
		else
			$display("[grid_ray_caster_column_unit] ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("[grid_ray_caster_column_unit] ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/gcc_pkg.sv
rtl/gcc_div.sv
rtl/grid_ray_caster_column_unit.sv
tb/grid_ray_caster_column_checker.sv
tb/tb_grid_ray_caster_column_unit.sv
